// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define AST_HOLD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define AST_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

// ----- rtl/kdsplit_pkg.sv -----
// ----------------------------------------------------------------------------
// Kd split package
// Types and constants shared by the kd-tree split block.
// ----------------------------------------------------------------------------
package kdsplit_pkg;

    localparam int COORD_BITS = 16;
    localparam int EXT_BITS   = COORD_BITS + 3;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_SPLIT = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic signed [EXT_BITS-1:0] BOX_MAX_START = -EXT_BITS'(1000);
    localparam logic signed [EXT_BITS-1:0] BOX_MIN_START = EXT_BITS'(1000);

    typedef struct packed {
        logic [1:0]                   action;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
        logic                         lower_median;
    } t_in;

    typedef struct packed {
        logic [1:0]                   status;
        logic [1:0]                   split_axis;
        logic signed [COORD_BITS-1:0] median_x;
        logic signed [COORD_BITS-1:0] median_y;
        logic signed [COORD_BITS-1:0] median_z;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BOX_RD,
        S_BOX_UP,
        S_AXIS,
        S_PASS,
        S_RUN_INIT,
        S_RA,
        S_RB,
        S_WR,
        S_MED_RD,
        S_MED_OUT
    } t_state;

endpackage

// ----- rtl/kd_split_axis_median.sv -----
// ----------------------------------------------------------------------------
// Kd split axis median
// Point store with widest-axis selection, stable merge sort and median.
// ----------------------------------------------------------------------------
// Items enter on i_valid/o_stall and leave on o_valid/i_stall; every item
// gives exactly one result item. A load stores one point and a clear empties
// the store; both are accepted back to back while the receiver does not stall.
// A split reads each stored point once for the bounding box, picks the widest
// axis, then runs a bottom-up merge sort along that axis between two point
// memories with one read port each, over ceil(log2 n) passes, and finally
// reads the median. No item is accepted while a split runs.
// Results sit in an output register; a new item is accepted while a result
// waits unless the receiver stalls and that register is still occupied.
// Reset empties the store and drops any pending result; memory contents are
// kept, and entries beyond the point count never affect a result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kd_split_axis_median #(
    parameter int MAX_POINTS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  kdsplit_pkg::t_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output kdsplit_pkg::t_out o_data
);

    localparam int CB = kdsplit_pkg::COORD_BITS;
    localparam int EB = kdsplit_pkg::EXT_BITS;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int XW = CW + 2;

    logic [3*CB-1:0] mem0 [MAX_POINTS];
    logic [3*CB-1:0] mem1 [MAX_POINTS];
    logic [3*CB-1:0] r_rd0, r_rd1, rd;

    kdsplit_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_bank, n_bank;
    logic          r_ov, n_ov;
    kdsplit_pkg::t_out r_out, n_out;
    logic [AW-1:0] r_idx, n_idx;
    logic [XW-1:0] r_w, n_w, r_lo, n_lo, r_mid, n_mid, r_hi, n_hi;
    logic [XW-1:0] r_a, n_a, r_b, n_b, r_o, n_o;
    logic [1:0]    r_axis, n_axis;
    logic [3*CB-1:0] r_pa, n_pa;
    logic signed [EB-1:0] r_bmax [3];
    logic signed [EB-1:0] r_bmin [3];
    logic signed [EB-1:0] n_bmax [3];
    logic signed [EB-1:0] n_bmin [3];

    logic          acc, out_free;
    logic          we, wbank;
    logic [AW-1:0] wa, ra;
    logic [3*CB-1:0] wd;
    logic [XW-1:0] nx, lo_w, lo_2w;
    logic [CW-1:0] m_med;
    logic signed [CB-1:0] va, vb;
    logic signed [EB-1:0] ext [3];
    logic signed [EB-1:0] best;
    logic          take_b;

    assign nx       = XW'(r_cnt);
    assign out_free = !r_ov || !i_stall;
    assign o_stall  = (r_state != kdsplit_pkg::S_IDLE) || !out_free;
    assign acc      = i_valid && !o_stall;
    assign rd       = r_bank ? r_rd1 : r_rd0;
    assign lo_w     = r_lo + r_w;
    assign lo_2w    = r_lo + (r_w << 1);
    assign m_med    = r_cnt - CW'(!r_cnt[0] && i_data.lower_median);

    always_comb begin
        case (r_axis)
            kdsplit_pkg::AXIS_Y: begin
                va = r_pa[2*CB-1:CB];
                vb = rd[2*CB-1:CB];
            end
            kdsplit_pkg::AXIS_Z: begin
                va = r_pa[CB-1:0];
                vb = rd[CB-1:0];
            end
            default: begin
                va = r_pa[3*CB-1:2*CB];
                vb = rd[3*CB-1:2*CB];
            end
        endcase
        take_b = (r_b < r_hi) && ((r_a >= r_mid) || (vb < va));
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ext[k] = r_bmax[k] - r_bmin[k];
            if (ext[k] < 0) begin
                ext[k] = -ext[k];
            end
        end
    end

    // Next state and register updates.
    always_comb begin
        logic signed [EB-1:0] cv;
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bank  = r_bank;
        n_ov    = r_ov && i_stall;
        n_out   = r_out;
        n_idx   = r_idx;
        n_w     = r_w;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_a     = r_a;
        n_b     = r_b;
        n_o     = r_o;
        n_axis  = r_axis;
        n_pa    = r_pa;
        n_bmax  = r_bmax;
        n_bmin  = r_bmin;
        best    = '0;
        cv      = '0;
        case (r_state)
            kdsplit_pkg::S_IDLE: begin
                if (acc) begin
                    n_out = '0;
                    case (i_data.action)
                        kdsplit_pkg::ACT_LOAD: begin
                            n_ov = 1'b1;
                            if (r_cnt >= CW'(MAX_POINTS)) begin
                                n_out.status = kdsplit_pkg::ST_FULL;
                            end else begin
                                n_cnt = r_cnt + 1'b1;
                            end
                        end
                        kdsplit_pkg::ACT_SPLIT: begin
                            if (r_cnt == '0) begin
                                n_ov = 1'b1;
                                n_out.status = kdsplit_pkg::ST_EMPTY;
                            end else begin
                                n_idx = AW'(m_med >> 1);
                                n_a   = '0;
                                for (int k = 0; k < 3; k++) begin
                                    n_bmax[k] = kdsplit_pkg::BOX_MAX_START;
                                    n_bmin[k] = kdsplit_pkg::BOX_MIN_START;
                                end
                                n_state = kdsplit_pkg::S_BOX_RD;
                            end
                        end
                        kdsplit_pkg::ACT_CLEAR: begin
                            n_ov  = 1'b1;
                            n_cnt = '0;
                        end
                        default: begin
                            n_ov = 1'b1;
                        end
                    endcase
                end
            end
            kdsplit_pkg::S_BOX_RD: begin
                n_state = (r_a == nx) ? kdsplit_pkg::S_AXIS : kdsplit_pkg::S_BOX_UP;
            end
            kdsplit_pkg::S_BOX_UP: begin
                for (int k = 0; k < 3; k++) begin
                    cv = EB'($signed(rd[(3-k)*CB-1 -: CB]));
                    if (cv > r_bmax[k]) begin
                        n_bmax[k] = cv;
                    end
                    if (cv < r_bmin[k]) begin
                        n_bmin[k] = cv;
                    end
                end
                n_a     = r_a + 1'b1;
                n_state = kdsplit_pkg::S_BOX_RD;
            end
            kdsplit_pkg::S_AXIS: begin
                n_axis = kdsplit_pkg::AXIS_X;
                best   = '0;
                for (int k = 0; k < 3; k++) begin
                    if (ext[k] > best) begin
                        best   = ext[k];
                        n_axis = 2'(k);
                    end
                end
                n_w     = XW'(1);
                n_state = kdsplit_pkg::S_PASS;
            end
            kdsplit_pkg::S_PASS: begin
                n_lo    = '0;
                n_state = (r_w >= nx) ? kdsplit_pkg::S_MED_RD : kdsplit_pkg::S_RUN_INIT;
            end
            kdsplit_pkg::S_RUN_INIT: begin
                if (r_lo >= nx) begin
                    n_bank  = !r_bank;
                    n_w     = r_w << 1;
                    n_state = kdsplit_pkg::S_PASS;
                end else begin
                    n_mid   = (lo_w > nx) ? nx : lo_w;
                    n_hi    = (lo_2w > nx) ? nx : lo_2w;
                    n_a     = r_lo;
                    n_b     = (lo_w > nx) ? nx : lo_w;
                    n_o     = r_lo;
                    n_state = kdsplit_pkg::S_RA;
                end
            end
            kdsplit_pkg::S_RA: begin
                n_state = kdsplit_pkg::S_RB;
            end
            kdsplit_pkg::S_RB: begin
                n_pa    = rd;
                n_state = kdsplit_pkg::S_WR;
            end
            kdsplit_pkg::S_WR: begin
                if (take_b) begin
                    n_b = r_b + 1'b1;
                end else begin
                    n_a = r_a + 1'b1;
                end
                n_o = r_o + 1'b1;
                if (r_o + 1'b1 == r_hi) begin
                    n_lo    = lo_2w;
                    n_state = kdsplit_pkg::S_RUN_INIT;
                end else begin
                    n_state = kdsplit_pkg::S_RA;
                end
            end
            kdsplit_pkg::S_MED_RD: begin
                n_state = kdsplit_pkg::S_MED_OUT;
            end
            kdsplit_pkg::S_MED_OUT: begin
                if (out_free) begin
                    n_ov             = 1'b1;
                    n_out.status     = kdsplit_pkg::ST_OK;
                    n_out.split_axis = r_axis;
                    n_out.median_x   = rd[3*CB-1:2*CB];
                    n_out.median_y   = rd[2*CB-1:CB];
                    n_out.median_z   = rd[CB-1:0];
                    n_state          = kdsplit_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kdsplit_pkg::S_IDLE;
            end
        endcase
    end

    // Memory controls.
    always_comb begin
        we      = 1'b0;
        wbank   = r_bank;
        wa      = r_cnt[AW-1:0];
        wd      = {i_data.coord_x, i_data.coord_y, i_data.coord_z};
        ra      = r_a[AW-1:0];
        case (r_state)
            kdsplit_pkg::S_IDLE: begin
                we = acc && (i_data.action == kdsplit_pkg::ACT_LOAD)
                    && (r_cnt < CW'(MAX_POINTS));
            end
            kdsplit_pkg::S_RB: begin
                ra = r_b[AW-1:0];
            end
            kdsplit_pkg::S_WR: begin
                we    = 1'b1;
                wbank = !r_bank;
                wa    = r_o[AW-1:0];
                wd    = take_b ? rd : r_pa;
            end
            kdsplit_pkg::S_MED_RD, kdsplit_pkg::S_MED_OUT: begin
                ra = r_idx;
            end
            default: begin
                ra = r_a[AW-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we && !wbank) begin
            mem0[wa] <= wd;
        end
        r_rd0 <= mem0[ra];
    end

    always_ff @(posedge i_clk) begin
        if (we && wbank) begin
            mem1[wa] <= wd;
        end
        r_rd1 <= mem1[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kdsplit_pkg::S_IDLE;
            r_cnt   <= '0;
            r_bank  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_bank  <= n_bank;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_idx  <= n_idx;
        r_w    <= n_w;
        r_lo   <= n_lo;
        r_mid  <= n_mid;
        r_hi   <= n_hi;
        r_a    <= n_a;
        r_b    <= n_b;
        r_o    <= n_o;
        r_axis <= n_axis;
        r_pa   <= n_pa;
        r_bmax <= n_bmax;
        r_bmin <= n_bmin;
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    `AST_HOLD(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(MAX_POINTS), "point count overflow")
    `AST_HOLD(a_wr_in_run, i_clk, i_rst_n, (r_state != kdsplit_pkg::S_WR) || ((r_o < r_hi) && (r_hi <= nx)), "merge write out of run")
    `AST_NEXT(a_busy_stall, i_clk, i_rst_n, r_state == kdsplit_pkg::S_BOX_RD, o_stall, "item accepted during split")
    `AST_HOLD(a_med_axis, i_clk, i_rst_n, (r_state != kdsplit_pkg::S_MED_OUT) || (r_axis <= kdsplit_pkg::AXIS_Z), "invalid split axis")

endmodule
